>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed");

// Implication checked on the following clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

>>> src/mdg_pkg.sv
// Types, codes and the divider step shared by the magic divisor generator.
package mdg_pkg;

	// algorithm register codes
	localparam logic [1:0] ALG_RSVD0   = 2'd0;
	localparam logic [1:0] ALG_SHIFT33 = 2'd1;
	localparam logic [1:0] ALG_SEARCH  = 2'd2;
	localparam logic [1:0] ALG_RSVD3   = 2'd3;
	localparam logic [1:0] ALG_RESET   = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_ALG  = 2'd1;
	localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

	// search runs p = 32..64, so up to 33 iterations
	localparam int DIV_STAGES  = 32;
	localparam int SRCH_STEPS  = 33;
	localparam logic [6:0] P_START = 7'd31;
	localparam logic [6:0] P_LIMIT = 7'd64;
	localparam logic [6:0] P_BASE  = 7'd32;
	localparam logic [31:0] HALF_WORD = 32'h8000_0000;
	localparam logic [31:0] HALF_MAX  = 32'h7FFF_FFFF;

	// long division of 2^31 by the divisor, one quotient bit per stage
	typedef struct packed {
		logic [31:0] d;
		logic [1:0]  alg;
		logic [31:0] rem;
		logic [31:0] quo;
	} div_t;

	// search state, one iteration per step
	typedef struct packed {
		logic [31:0] d;
		logic [1:0]  alg;
		logic        act;
		logic [6:0]  p;
		logic [31:0] nc;
		logic [31:0] q1;
		logic [31:0] r1;
		logic [31:0] q2;
		logic [31:0] r2;
		logic        add;
		logic [31:0] m1_mul;
		logic [5:0]  m1_sh;
	} srch_t;

	// one restoring division step, shifting in one dividend bit
	function automatic div_t div_step(div_t x, logic dbit);
		logic [33:0] diff;
		div_t        y;
		diff = {1'b0, x.rem, dbit} - {2'b00, x.d};
		y = x;
		y.quo = {x.quo[30:0], ~diff[33]};
		y.rem = diff[33] ? {x.rem[30:0], dbit} : diff[31:0];
		return y;
	endfunction

endpackage

>>> src/mdg_ifs.sv
// Channel interfaces: divisor request, magic result and configuration write.
interface mdg_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] divisor;
	modport source (output valid, output divisor, input ready);
	modport sink (input valid, input divisor, output ready);
endinterface

interface mdg_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] multiplier;
	logic [5:0]  shift_amount;
	logic        add_flag;
	logic [1:0]  status;
	modport source (output valid, output multiplier, output shift_amount,
		output add_flag, output status, input ready);
	modport sink (input valid, input multiplier, input shift_amount,
		input add_flag, input status, output ready);
endinterface

interface mdg_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] algorithm;
	modport source (output valid, output algorithm, input ready);
	modport sink (input valid, input algorithm, output ready);
endinterface

>>> src/mdg_srch_step.sv
// One iteration of the magic search: update stage, then termination check stage.
module mdg_srch_step
	import mdg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  srch_t in_w,
	output logic  out_vld,
	output srch_t out_w
);

	logic  a_vld_s1;
	srch_t a_s1;
	srch_t upd;
	srch_t chk;
	logic [33:0] t1;
	logic [33:0] t2;
	logic [32:0] sum;
	logic        more;

	// quotient/remainder doubling for both sides of the search
	always_comb begin
		t1 = {1'b0, in_w.r1, 1'b0} - {2'b00, in_w.nc};
		t2 = {1'b0, in_w.r2, 1'b1} - {2'b00, in_w.d};
		upd = in_w;
		if (in_w.act) begin
			upd.p = in_w.p + 7'd1;
			if (!t1[33]) begin
				upd.q1 = {in_w.q1[30:0], 1'b1};
				upd.r1 = t1[31:0];
			end else begin
				upd.q1 = {in_w.q1[30:0], 1'b0};
				upd.r1 = {in_w.r1[30:0], 1'b0};
			end
			if (!t2[33]) begin
				if (in_w.q2 >= HALF_MAX) upd.add = 1'b1;
				upd.q2 = {in_w.q2[30:0], 1'b1};
				upd.r2 = t2[31:0];
			end else begin
				if (in_w.q2[31]) upd.add = 1'b1;
				upd.q2 = {in_w.q2[30:0], 1'b0};
				upd.r2 = {in_w.r2[30:0], 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s1 <= 1'b0;
		end else if (en) begin
			a_vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) a_s1 <= upd;
	end

	// continue while p < 64 and either q1 < d-1-r2, or q1 equals it with zero r1
	always_comb begin
		sum = {1'b0, a_s1.q1} + {1'b0, a_s1.r2} + 33'd1;
		more = (a_s1.p < P_LIMIT) &&
			((sum < {1'b0, a_s1.d}) ||
			((sum == {1'b0, a_s1.d}) && (a_s1.r1 == 32'd0)));
		chk = a_s1;
		chk.act = a_s1.act & more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= a_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_w <= chk;
	end

endmodule

>>> src/magic_divisor_generator.sv
// Top level of the magic divisor generator.
// Magic divisor generator: for each divisor word it returns a multiplier and a
// right shift (plus an add indicator in the search method) that replace an
// unsigned division by multiply-high and shift. The work is a straight pipeline
// that takes one word per cycle: 32 stages of restoring division of 2^31 by
// the divisor, two setup stages, 33 search iterations of two stages each, and
// the output register. A stall at the output halts the whole pipeline. The
// algorithm register may be written at any time the pipeline is empty; the
// value in force when a word enters applies to it.
`include "assert_macros.svh"
module magic_divisor_generator
	import mdg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mdg_cfg_if.sink cfg,
	mdg_req_if.sink req,
	mdg_rsp_if.source rsp
);

	logic       adv;
	logic [1:0] alg_q;

	logic  div_vld_s1 [DIV_STAGES];
	div_t  div_s1 [DIV_STAGES];

	logic        pre_vld_s2;
	div_t        pre_s2;
	logic [32:0] q32_s2;
	logic [31:0] r32_s2;
	logic [31:0] q2i_s2;
	logic [31:0] r2i_s2;

	logic  srch_vld_s3;
	srch_t srch_s3;

	logic  stp_vld [SRCH_STEPS+1];
	srch_t stp_w [SRCH_STEPS+1];

	logic        out_vld_s4;
	logic [31:0] mul_s4;
	logic [5:0]  sh_s4;
	logic        add_s4;
	logic [1:0]  st_s4;

	// whole pipeline moves when the output slot is free or being taken
	assign adv = !out_vld_s4 || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	// algorithm register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= ALG_RESET;
		end else if (cfg.valid) begin
			alg_q <= cfg.algorithm;
		end
	end

	// divider stages: dividend 2^31, MSB first
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		div_t src;
		logic src_vld;
		if (g == 0) begin : g_first
			always_comb begin
				src.d = req.divisor;
				src.alg = alg_q;
				src.rem = 32'd0;
				src.quo = 32'd0;
				src_vld = req.valid;
			end
		end else begin : g_rest
			always_comb begin
				src = div_s1[g-1];
				src_vld = div_vld_s1[g-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s1[g] <= 1'b0;
			end else if (adv) begin
				div_vld_s1[g] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) div_s1[g] <= div_step(src, (g == 0) ? 1'b1 : 1'b0);
		end
	end

	// setup 1: 2^32 / d, and (2^31-1) / d from 2^31 / d
	logic [33:0] t32;
	div_t        dl;
	always_comb begin
		dl = div_s1[DIV_STAGES-1];
		t32 = {1'b0, dl.rem, 1'b0} - {2'b00, dl.d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s2 <= 1'b0;
		end else if (adv) begin
			pre_vld_s2 <= div_vld_s1[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s2 <= dl;
			q32_s2 <= {dl.quo, ~t32[33]};
			r32_s2 <= t32[33] ? {dl.rem[30:0], 1'b0} : t32[31:0];
			if (dl.rem == 32'd0) begin
				q2i_s2 <= dl.quo - 32'd1;
				r2i_s2 <= dl.d - 32'd1;
			end else begin
				q2i_s2 <= dl.quo;
				r2i_s2 <= dl.rem - 32'd1;
			end
		end
	end

	// setup 2: 2^33 / d for shift-33 method, nc and q1/r1 for the search
	logic [33:0] t33;
	logic [33:0] q33;
	logic [31:0] nc;
	srch_t       init;
	always_comb begin
		t33 = {1'b0, r32_s2, 1'b0} - {2'b00, pre_s2.d};
		q33 = {q32_s2, ~t33[33]};
		nc = ~r32_s2;
		init.d = pre_s2.d;
		init.alg = pre_s2.alg;
		init.act = 1'b1;
		init.p = P_START;
		init.nc = nc;
		init.q1 = (nc == HALF_WORD) ? 32'd1 : 32'd0;
		init.r1 = (nc == HALF_WORD) ? 32'd0 : HALF_WORD;
		init.q2 = q2i_s2;
		init.r2 = r2i_s2;
		init.add = 1'b0;
		if (q33 >= 34'h0_FFFF_FFFF) begin
			init.m1_mul = pre_s2.quo + 32'd1;
			init.m1_sh = 6'd31;
		end else begin
			init.m1_mul = q33[31:0] + 32'd1;
			init.m1_sh = 6'd33;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_vld_s3 <= 1'b0;
		end else if (adv) begin
			srch_vld_s3 <= pre_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) srch_s3 <= init;
	end

	// search iterations
	assign stp_vld[0] = srch_vld_s3;
	assign stp_w[0] = srch_s3;
	for (genvar k = 0; k < SRCH_STEPS; k++) begin : g_srch
		mdg_srch_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.in_vld  (stp_vld[k]),
			.in_w    (stp_w[k]),
			.out_vld (stp_vld[k+1]),
			.out_w   (stp_w[k+1])
		);
	end

	// result select and output register
	srch_t       fin;
	logic [31:0] mul_n;
	logic [5:0]  sh_n;
	logic        add_n;
	logic [1:0]  st_n;
	logic [6:0]  shp;
	always_comb begin
		fin = stp_w[SRCH_STEPS];
		shp = fin.p - P_BASE;
		mul_n = 32'd0;
		sh_n = 6'd0;
		add_n = 1'b0;
		st_n = STATUS_OK;
		case (fin.alg)
			ALG_SHIFT33: begin
				if (fin.d == 32'd0) begin
					st_n = STATUS_ZERO_DIV;
				end else begin
					mul_n = fin.m1_mul;
					sh_n = fin.m1_sh;
				end
			end
			ALG_SEARCH: begin
				if (fin.d != 32'd0) begin
					mul_n = fin.q2 + 32'd1;
					sh_n = shp[5:0];
					add_n = fin.add;
				end
			end
			default: begin
				st_n = STATUS_BAD_ALG;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s4 <= 1'b0;
		end else if (adv) begin
			out_vld_s4 <= stp_vld[SRCH_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s4 <= mul_n;
			sh_s4 <= sh_n;
			add_s4 <= add_n;
			st_s4 <= st_n;
		end
	end

	assign rsp.valid = out_vld_s4;
	assign rsp.multiplier = mul_s4;
	assign rsp.shift_amount = sh_s4;
	assign rsp.add_flag = add_s4;
	assign rsp.status = st_s4;

	// error words carry no magic pair
	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_vld_s4 && (st_s4 != STATUS_OK), (mul_s4 == 32'd0) && (sh_s4 == 6'd0) && !add_s4)
	// shift never exceeds 33
	`ASSERT_IMPL(a_sh_range, clk, arst_n, out_vld_s4, sh_s4 <= 6'd33)
	// a stalled output word holds until taken
	`ASSERT_NEXT(a_hold, clk, arst_n, out_vld_s4 && !rsp.ready, out_vld_s4 && $stable(mul_s4) && $stable(sh_s4))
	// a word leaving the search has stopped iterating
	`ASSERT_IMPL(a_srch_done, clk, arst_n, stp_vld[SRCH_STEPS], !stp_w[SRCH_STEPS].act || (stp_w[SRCH_STEPS].p == P_LIMIT))

endmodule

>>> tb/testbench.sv
// Testbench for the magic divisor generator: random and directed divisors checked field by field.
`timescale 1ns / 100ps
module testbench;
	import mdg_pkg::*;

	typedef struct packed {
		logic [31:0] multiplier;
		logic [5:0]  shift_amount;
		logic        add_flag;
		logic [1:0]  status;
	} magic_t;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mdg_cfg_if cfg_ch();
	mdg_req_if req_ch();
	mdg_rsp_if rsp_ch();

	magic_divisor_generator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch.sink), .req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always #5 clk = ~clk;

	logic [31:0] divisor_queue[$];
	magic_t      magic_expected[$];
	logic [1:0]  alg_model = ALG_RESET;
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;
	bit          cfg_pending = 0;
	logic [1:0]  cfg_value;
	bit          cfg_done = 0;
	bit          req_fire = 0;

	// compute the expected magic pair for one divisor under the current algorithm
	function automatic magic_t compute_magic(logic [1:0] alg, logic [31:0] d);
		magic_t r;
		logic [63:0] m;
		logic [31:0] nc, delta, q1, r1, q2, r2, p;
		bit more;
		r = '0;
		if (alg == ALG_SHIFT33) begin
			if (d == 0) begin
				r.status = STATUS_ZERO_DIV;
			end else begin
				m = (64'd1 << 33) / d + 64'd1;
				r.shift_amount = 6'd33;
				if (m[63:32] != 0) begin
					m = (64'd1 << 31) / d + 64'd1;
					r.shift_amount = 6'd31;
				end
				r.multiplier = m[31:0];
			end
		end else if (alg == ALG_SEARCH) begin
			if (d != 0) begin
				nc = 32'hFFFF_FFFF - ((32'd0 - d) % d);
				p = 31;
				q1 = HALF_WORD / nc;
				r1 = HALF_WORD - q1 * nc;
				q2 = HALF_MAX / d;
				r2 = HALF_MAX - q2 * d;
				do begin
					p = p + 1;
					if (r1 >= nc - r1) begin
						q1 = 2 * q1 + 1;
						r1 = 2 * r1 - nc;
					end else begin
						q1 = 2 * q1;
						r1 = 2 * r1;
					end
					if (r2 + 32'd1 >= d - r2) begin
						if (q2 >= HALF_MAX) r.add_flag = 1'b1;
						q2 = 2 * q2 + 1;
						r2 = 2 * r2 + 1 - d;
					end else begin
						if (q2 >= HALF_WORD) r.add_flag = 1'b1;
						q2 = 2 * q2;
						r2 = 2 * r2 + 1;
					end
					delta = d - 32'd1 - r2;
					more = (p < 64) && (q1 < delta || (q1 == delta && r1 == 0));
				end while (more);
				r.multiplier = q2 + 32'd1;
				r.shift_amount = 6'(p - 32);
			end
		end else begin
			r.status = STATUS_BAD_ALG;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		error_count++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// append one divisor to the pending queue
	task automatic queue_divisor(input logic [31:0] d);
		divisor_queue = {divisor_queue, d};
	endtask

	// driver: request word, config write and result ready, changed at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.divisor <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.algorithm <= '0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (cfg_ch.valid && cfg_ch.ready) begin
				cfg_ch.valid <= 1'b0;
			end else if (cfg_pending && !cfg_ch.valid) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.algorithm <= cfg_value;
			end
			// a word moves on only once the last rising edge took it
			if (!req_ch.valid || req_fire) begin
				if (divisor_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.divisor <= divisor_queue.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict at request acceptance, check at result acceptance
	always @(posedge clk) begin
		magic_t got, want;
		bit     busy;
		busy = 0;
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				alg_model = cfg_ch.algorithm;
				cfg_done = 1;
				busy = 1;
			end
			if (req_ch.valid && req_ch.ready) begin
				magic_expected = {magic_expected, compute_magic(alg_model, req_ch.divisor)};
				busy = 1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				busy = 1;
				got = {rsp_ch.multiplier, rsp_ch.shift_amount, rsp_ch.add_flag, rsp_ch.status};
				if (magic_expected.size() == 0) begin
					report_mismatch("unexpected word", got.multiplier, 32'd0);
				end else begin
					want = magic_expected.pop_front();
					if (got.multiplier !== want.multiplier)
						report_mismatch("multiplier", got.multiplier, want.multiplier);
					if (got.shift_amount !== want.shift_amount)
						report_mismatch("shift_amount", 32'(got.shift_amount),
							32'(want.shift_amount));
					if (got.add_flag !== want.add_flag)
						report_mismatch("add_flag", 32'(got.add_flag), 32'(want.add_flag));
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
				end
			end
			quiet_cycles <= busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic [31:0] random_divisor();
		case ($urandom_range(5))
			0: return $urandom_range(16);
			1: return 32'hFFFF_FFFF - $urandom_range(16);
			2: return 32'd1 << $urandom_range(31);
			3: return $urandom & (32'hFFFF_FFFF >> $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	// wait until the pipeline has drained, then write the algorithm register
	task automatic set_algorithm(input logic [1:0] alg);
		wait (divisor_queue.size() == 0 && !req_ch.valid && magic_expected.size() == 0);
		repeat (4) @(posedge clk);
		cfg_done = 0;
		cfg_value = alg;
		cfg_pending = 1;
		wait (cfg_done);
		cfg_pending = 0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) queue_divisor(random_divisor());
		wait (divisor_queue.size() == 0 && !req_ch.valid);
	endtask

	initial begin
		logic [31:0] corner[$];
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: extremes under reset algorithm, then each code
		// 3969050863 divides 2^63-1 and runs the search all the way to p = 64
		corner = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'd641, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
			32'd3969050863};
		foreach (corner[i]) queue_divisor(corner[i]);
		run_phase(0, 0, 0);
		for (int a = 0; a < 4; a++) begin
			set_algorithm(2'(a));
			queue_divisor(32'd0);
			queue_divisor(32'd1);
			queue_divisor(32'd2);
			queue_divisor(32'd3);
			queue_divisor(32'hFFFF_FFFF);
			run_phase(0, 0, 0);
		end

		// random phases across idle and stall patterns and algorithms
		set_algorithm(ALG_SEARCH);
		run_phase(60, 0, 0);
		run_phase(50, 59, 0);
		set_algorithm(ALG_SHIFT33);
		run_phase(60, 0, 59);
		run_phase(50, 37, 37);
		set_algorithm(ALG_RSVD0);
		run_phase(15, 59, 59);
		set_algorithm(ALG_SEARCH);
		run_phase(80, 37, 37);
		// sender holds off until all results are back
		wait (magic_expected.size() == 0);
		run_phase(60, 0, 59);
		set_algorithm(ALG_RSVD3);
		run_phase(15, 0, 0);
		set_algorithm(ALG_SHIFT33);
		run_phase(80, 59, 0);

		wait (magic_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && magic_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
